>>> hw/rtl/aging_bloom_retransmit_detector_top_macros.svh
// Assertion helpers for the retransmit detector.
`ifndef AGING_BLOOM_RETRANSMIT_DETECTOR_TOP_MACROS_SVH
`define AGING_BLOOM_RETRANSMIT_DETECTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/abrd_pkg.sv
package abrd_pkg;

    localparam int NUM_HASH = 3;
    localparam int HASH_W   = 32;
    localparam int BIT_W    = 6;
    localparam int WORDQ_W  = HASH_W - BIT_W;
    localparam int EPOCH_W  = 40;
    localparam int GEN_W    = 64;
    localparam int TIME_W   = 64;
    localparam int LANE_W   = 64;

    localparam logic [HASH_W-1:0] HASH_GOLDEN = 32'h9e37_79b9;
    localparam logic [NUM_HASH-1:0][HASH_W-1:0] HASH_SEEDS =
        {32'hdead_beef, 32'h9e37_79b9, 32'h1234_5678};
    localparam logic [EPOCH_W-1:0] EPOCH_RESET = 40'd1500000000;

    typedef struct packed {
        logic [GEN_W-1:0]  tag;
        logic [LANE_W-1:0] bits;
    } word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PASS,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3
    } seq_state_t;

    function automatic logic [HASH_W-1:0] mix_head(
        input logic [HASH_W-1:0] seed,
        input logic [HASH_W-1:0] sa,
        input logic [HASH_W-1:0] da
    );
        logic [HASH_W-1:0] h;
        h = seed ^ sa;
        h = h ^ (da + HASH_GOLDEN + (h << 6) + (h >> 2));
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] mix_tail(
        input logic [HASH_W-1:0] hin,
        input logic [HASH_W-1:0] ports,
        input logic [HASH_W-1:0] key
    );
        logic [HASH_W-1:0] h;
        h = hin ^ ports;
        h = h ^ (key + HASH_GOLDEN + (h << 6) + (h >> 2));
        return h;
    endfunction

    function automatic word_t mark_word(
        input word_t             w,
        input logic [LANE_W-1:0] m,
        input logic [GEN_W-1:0]  gen
    );
        word_t r;
        r.tag  = gen;
        r.bits = ((w.tag == gen) ? w.bits : '0) | m;
        return r;
    endfunction

endpackage

>>> hw/rtl/abrd_if.sv
interface abrd_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic        has_payload;
    logic        syn_flag;
    logic        ack_flag;
    logic        fin_flag;
    logic        rst_flag;
    logic [63:0] timestamp_ns;

    modport source (
        output valid, src_addr, dst_addr, src_port, dst_port, seq_num,
               has_payload, syn_flag, ack_flag, fin_flag, rst_flag, timestamp_ns,
        input  ready
    );
    modport sink (
        input  valid, src_addr, dst_addr, src_port, dst_port, seq_num,
               has_payload, syn_flag, ack_flag, fin_flag, rst_flag, timestamp_ns,
        output ready
    );
endinterface

interface abrd_res_if;
    logic valid;
    logic ready;
    logic was_tested;
    logic is_retransmit;

    modport source (output valid, was_tested, is_retransmit, input ready);
    modport sink   (input valid, was_tested, is_retransmit, output ready);
endinterface

>>> hw/rtl/abrd_ram.sv
module abrd_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/aging_bloom_retransmit_detector_top.sv
// Flags retransmitted TCP segments with a two-generation aging Bloom filter. A request
// enters a five-stage hash pipeline every cycle it is not stalled; the filter core then
// takes a tested segment through ST_P0 to ST_P3 (three word reads of both halves, three
// read-modify-writes through the single write port of the current half's RAM) and
// a segment that is not tested through ST_PASS alone, and loads a new request only when
// it is idle or the current one emits its result. The bit store is two RAMs of
// WORDS_PER_HALF words of 128 bits (generation tag and bit lane); after reset a
// clearing pass over every word of both halves runs during which no request is accepted,
// while epoch length writes are taken at any time.
`include "aging_bloom_retransmit_detector_top_macros.svh"

module aging_bloom_retransmit_detector_top #(
    parameter int WORDS_PER_HALF = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    abrd_seg_if.sink                     seg,
    abrd_res_if.source                   res,
    input  logic                         cfg_we,
    input  logic [abrd_pkg::EPOCH_W-1:0] cfg_wdata
);
    import abrd_pkg::*;

    localparam int AW = $clog2(WORDS_PER_HALF);
    localparam int XW = WORDQ_W;
    localparam int PW = 2 * XW + 1;
    localparam longint unsigned RECIP_VAL = (64'd1 << XW) / WORDS_PER_HALF;
    localparam logic [XW:0]   RECIP    = (XW+1)'(RECIP_VAL);
    localparam logic [AW:0]   DIV      = (AW+1)'(WORDS_PER_HALF);
    localparam logic [AW-1:0] CLR_LAST = AW'(WORDS_PER_HALF - 1);

    // epoch and configuration
    logic [EPOCH_W-1:0] epoch_len_reg;
    logic [GEN_W-1:0]   gen_reg, gen_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic               seg_fire, seg_ignore, seg_roll, seg_test;
    logic [TIME_W-1:0]  elapsed;

    // hash pipeline
    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_test_reg, s2_test_reg, s3_test_reg, s4_test_reg, s5_test_reg;
    logic [GEN_W-1:0] s1_gen_reg, s2_gen_reg, s3_gen_reg, s4_gen_reg, s5_gen_reg;
    logic [HASH_W-1:0] s1_sa_reg, s1_da_reg, s1_ports_reg, s1_key_reg;
    logic [HASH_W-1:0] s2_ports_reg, s2_key_reg;
    logic [NUM_HASH-1:0][HASH_W-1:0] s2_h_reg;
    logic [NUM_HASH-1:0][XW-1:0]     s3_x_reg, s4_x_reg;
    logic [NUM_HASH-1:0][BIT_W-1:0]  s3_bit_reg, s4_bit_reg, s5_bit_reg;
    logic [NUM_HASH-1:0][XW-1:0]     s4_q_reg;
    logic [NUM_HASH-1:0][AW:0]       s5_r_reg;
    logic [NUM_HASH-1:0][HASH_W-1:0] h_full;
    logic [NUM_HASH-1:0][PW-1:0]     prod;
    logic [NUM_HASH-1:0][XW-1:0]     qd;
    logic [NUM_HASH-1:0][AW:0]       word_fix;

    // filter core
    seq_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [GEN_W-1:0] job_gen_reg, gen_prev;
    logic [NUM_HASH-1:0][AW-1:0]    job_word_reg;
    logic [NUM_HASH-1:0][BIT_W-1:0] job_bit_reg;
    logic [NUM_HASH-1:0][LANE_W-1:0] mask;
    logic [NUM_HASH-1:0] hit;
    logic same01, same02, same12;
    logic job_load, can_load, seq_done, emit, emit_tested, emit_retx;
    logic [1:0] half_we;
    word_t d0_cur_reg, d0_prev_reg, d1_cur_reg, d1_prev_reg;
    word_t cur_rd, prev_rd, rdata0, rdata1;
    word_t src_cur [NUM_HASH];
    word_t src_prev [NUM_HASH];

    // memory ports
    logic [1:0]    ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    word_t         ram_wdata;
    logic          ram_re;

    // result register
    logic res_valid_reg, res_valid_next;
    logic res_tested_reg, res_retx_reg;

    assign seg_fire   = seg.valid && seg.ready;
    assign seg_ignore = !(seg.has_payload || seg.syn_flag || seg.fin_flag || seg.rst_flag);
    assign seg_test   = seg.has_payload || (seg.syn_flag && !seg.ack_flag);
    assign elapsed    = seg.timestamp_ns - start_reg;
    assign seg_roll   = !seg_ignore && (seg.timestamp_ns > start_reg) &&
                        (elapsed > {{(TIME_W-EPOCH_W){1'b0}}, epoch_len_reg});

    always_comb
    begin
        gen_next   = gen_reg;
        start_next = start_reg;
        if (seg_fire && seg_roll)
        begin
            gen_next   = gen_reg + 64'd1;
            start_next = seg.timestamp_ns;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_len_reg <= EPOCH_RESET;
            gen_reg       <= '0;
            start_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                epoch_len_reg <= cfg_wdata;
            end
            gen_reg   <= gen_next;
            start_reg <= start_next;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= seg_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_HASH; i++)
        begin
            h_full[i]   = mix_tail(s2_h_reg[i], s2_ports_reg, s2_key_reg);
            prod[i]     = PW'(s3_x_reg[i]) * PW'(RECIP);
            qd[i]       = XW'(s4_q_reg[i] * XW'(DIV));
            word_fix[i] = (s5_r_reg[i] >= DIV) ? (s5_r_reg[i] - DIV) : s5_r_reg[i];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_test_reg  <= seg_test;
            s1_gen_reg   <= seg_roll ? (gen_reg + 64'd1) : gen_reg;
            s1_sa_reg    <= seg.src_addr;
            s1_da_reg    <= seg.dst_addr;
            s1_ports_reg <= {seg.src_port, seg.dst_port};
            s1_key_reg   <= seg.has_payload ? {4'b0000, seg.seq_num[31:4]} : seg.seq_num;

            s2_test_reg  <= s1_test_reg;
            s2_gen_reg   <= s1_gen_reg;
            s2_ports_reg <= s1_ports_reg;
            s2_key_reg   <= s1_key_reg;
            s3_test_reg  <= s2_test_reg;
            s3_gen_reg   <= s2_gen_reg;
            s4_test_reg  <= s3_test_reg;
            s4_gen_reg   <= s3_gen_reg;
            s4_x_reg     <= s3_x_reg;
            s4_bit_reg   <= s3_bit_reg;
            s5_test_reg  <= s4_test_reg;
            s5_gen_reg   <= s4_gen_reg;
            s5_bit_reg   <= s4_bit_reg;
            for (int i = 0; i < NUM_HASH; i++)
            begin
                s2_h_reg[i]   <= mix_head(HASH_SEEDS[i], s1_sa_reg, s1_da_reg);
                s3_x_reg[i]   <= h_full[i][HASH_W-1:BIT_W];
                s3_bit_reg[i] <= h_full[i][BIT_W-1:0];
                s4_q_reg[i]   <= prod[i][XW +: XW];
                s5_r_reg[i]   <= (AW+1)'(s4_x_reg[i] - qd[i]);
            end
        end
    end

    // bit store
    abrd_ram #(
        .WIDTH ($bits(word_t)),
        .DEPTH (WORDS_PER_HALF)
    ) u_ram_even (
        .clk   (clk),
        .we    (ram_we[0]),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata0)
    );

    abrd_ram #(
        .WIDTH ($bits(word_t)),
        .DEPTH (WORDS_PER_HALF)
    ) u_ram_odd (
        .clk   (clk),
        .we    (ram_we[1]),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata1)
    );

    assign cur_rd   = job_gen_reg[0] ? rdata1 : rdata0;
    assign prev_rd  = job_gen_reg[0] ? rdata0 : rdata1;
    assign half_we  = job_gen_reg[0] ? 2'b10 : 2'b01;
    assign gen_prev = job_gen_reg - 64'd1;
    assign same01   = job_word_reg[0] == job_word_reg[1];
    assign same02   = job_word_reg[0] == job_word_reg[2];
    assign same12   = job_word_reg[1] == job_word_reg[2];

    // forward the first read of a word so every probe sees the pre-request contents
    always_comb
    begin
        src_cur[0]  = d0_cur_reg;
        src_prev[0] = d0_prev_reg;
        src_cur[1]  = same01 ? d0_cur_reg : d1_cur_reg;
        src_prev[1] = same01 ? d0_prev_reg : d1_prev_reg;
        src_cur[2]  = same02 ? d0_cur_reg : (same12 ? d1_cur_reg : cur_rd);
        src_prev[2] = same02 ? d0_prev_reg : (same12 ? d1_prev_reg : prev_rd);
        for (int k = 0; k < NUM_HASH; k++)
        begin
            mask[k] = '0;
            for (int j = 0; j < NUM_HASH; j++)
            begin
                if (job_word_reg[j] == job_word_reg[k])
                begin
                    mask[k] = mask[k] | (64'd1 << job_bit_reg[j]);
                end
            end
            hit[k] = ((src_cur[k].tag == job_gen_reg) &&
                      src_cur[k].bits[job_bit_reg[k]]) ||
                     ((src_prev[k].tag == gen_prev) &&
                      src_prev[k].bits[job_bit_reg[k]]);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        job_load     = 1'b0;
        seq_done     = 1'b0;
        emit         = 1'b0;
        emit_tested  = 1'b0;
        emit_retx    = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = job_word_reg[0];
        ram_we       = 2'b00;
        ram_waddr    = job_word_reg[0];
        ram_wdata    = mark_word(cur_rd, mask[0], job_gen_reg);
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 2'b11;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_PASS:
            begin
                if (!res_valid_reg)
                begin
                    emit     = 1'b1;
                    seq_done = 1'b1;
                end
            end
            ST_P0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = job_word_reg[0];
                state_next = ST_P1;
            end
            ST_P1:
            begin
                ram_re     = 1'b1;
                ram_raddr  = job_word_reg[1];
                ram_we     = half_we;
                ram_waddr  = job_word_reg[0];
                ram_wdata  = mark_word(cur_rd, mask[0], job_gen_reg);
                state_next = ST_P2;
            end
            ST_P2:
            begin
                ram_re     = 1'b1;
                ram_raddr  = job_word_reg[2];
                ram_we     = half_we;
                ram_waddr  = job_word_reg[1];
                ram_wdata  = mark_word(same01 ? d0_cur_reg : cur_rd, mask[1], job_gen_reg);
                state_next = ST_P3;
            end
            ST_P3:
            begin
                ram_we    = half_we;
                ram_waddr = job_word_reg[2];
                ram_wdata = mark_word(src_cur[2], mask[2], job_gen_reg);
                if (!res_valid_reg)
                begin
                    emit        = 1'b1;
                    emit_tested = 1'b1;
                    emit_retx   = &hit;
                    seq_done    = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        can_load = (state_reg == ST_IDLE) || seq_done;
        if (can_load)
        begin
            if (s5_valid_reg)
            begin
                job_load   = 1'b1;
                state_next = s5_test_reg ? ST_P0 : ST_PASS;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    assign adv       = !s5_valid_reg || can_load;
    assign seg.ready = adv && (state_reg != ST_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // hold the request, the first two reads and the result flags
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_gen_reg <= s5_gen_reg;
            job_bit_reg <= s5_bit_reg;
            for (int i = 0; i < NUM_HASH; i++)
            begin
                job_word_reg[i] <= word_fix[i][AW-1:0];
            end
        end
        if (state_reg == ST_P1)
        begin
            d0_cur_reg  <= cur_rd;
            d0_prev_reg <= prev_rd;
        end
        if (state_reg == ST_P2)
        begin
            d1_cur_reg  <= cur_rd;
            d1_prev_reg <= prev_rd;
        end
        if (emit)
        begin
            res_tested_reg <= emit_tested;
            res_retx_reg   <= emit_retx;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.was_tested    = res_tested_reg;
    assign res.is_retransmit = res_retx_reg;

    `ABRD_ASSERT_NOW(a_no_request_in_clear, state_reg == ST_CLEAR, !seg.ready, "request accepted during clear")
    `ABRD_ASSERT_NOW(a_one_half_written, state_reg != ST_CLEAR, !(ram_we[0] && ram_we[1]), "both halves written outside clear")
    `ABRD_ASSERT_NEXT(a_last_write_holds, (state_reg == ST_P3) && res_valid_reg, state_reg == ST_P3, "final write left while result pending")
    `ABRD_ASSERT_NEXT(a_gen_single_step, 1'b1, (gen_reg == $past(gen_reg)) || (gen_reg == $past(gen_reg) + 64'd1), "generation jumped")

endmodule

>>> tb/tb_top.sv
module tb_top;
    import abrd_pkg::*;

    localparam int HALF_WORDS = 4096;
    localparam int HALF_BITS  = HALF_WORDS * 64;

    localparam bit [4:0] F_NONE = 5'b00000;
    localparam bit [4:0] F_PAY  = 5'b10000;
    localparam bit [4:0] F_SYN  = 5'b01000;
    localparam bit [4:0] F_ACK  = 5'b00100;
    localparam bit [4:0] F_FIN  = 5'b00010;
    localparam bit [4:0] F_RST  = 5'b00001;

    localparam bit [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef struct {
        bit [31:0] src_addr;
        bit [31:0] dst_addr;
        bit [15:0] src_port;
        bit [15:0] dst_port;
        bit [31:0] seq_num;
        bit        has_payload;
        bit        syn_flag;
        bit        ack_flag;
        bit        fin_flag;
        bit        rst_flag;
        bit [63:0] timestamp_ns;
    } tcp_seg_t;

    typedef struct packed {
        bit was_tested;
        bit is_retransmit;
    } verdict_t;

    typedef struct {
        bit [31:0] sa;
        bit [31:0] da;
        bit [15:0] sp;
        bit [15:0] dp;
        bit [31:0] data_seq;
        bit [31:0] syn_seq;
    } flow_t;

    class bloom_shadow;
        bit [EPOCH_W-1:0] epoch_len;
        bit [63:0]        generation;
        bit [63:0]        epoch_start;
        bit [63:0]        tag_store[2*HALF_WORDS];
        bit [63:0]        lane_store[2*HALF_WORDS];
        verdict_t         verdict_q[$];
        int unsigned      mismatches;

        function new();
            epoch_len   = EPOCH_RESET;
            generation  = '0;
            epoch_start = '0;
            mismatches  = 0;
            foreach (tag_store[i])
            begin
                tag_store[i]  = '0;
                lane_store[i] = '0;
            end
        endfunction

        function void set_epoch(bit [EPOCH_W-1:0] v);
            epoch_len = v;
        endfunction

        function bit [31:0] spread(bit [31:0] seed, tcp_seg_t s, bit [31:0] key);
            bit [31:0] h;
            h = seed ^ s.src_addr;
            h = h ^ (s.dst_addr + HASH_GOLDEN + (h << 6) + (h >> 2));
            h = h ^ {s.src_port, s.dst_port};
            h = h ^ (key + HASH_GOLDEN + (h << 6) + (h >> 2));
            return h;
        endfunction

        function int unsigned slot_of(bit [31:0] bp, bit [63:0] g);
            return (g[0] ? HALF_WORDS : 0) + ((bp >> 6) % HALF_WORDS);
        endfunction

        function bit seen(bit [31:0] bp, bit [63:0] g);
            int unsigned i;
            i = slot_of(bp, g);
            return (tag_store[i] == g) && lane_store[i][bp[5:0]];
        endfunction

        function void set_bit(bit [31:0] bp, bit [63:0] g);
            int unsigned i;
            i = slot_of(bp, g);
            if (tag_store[i] != g)
            begin
                tag_store[i]  = g;
                lane_store[i] = '0;
            end
            lane_store[i][bp[5:0]] = 1'b1;
        endfunction

        function void note_segment(tcp_seg_t s);
            verdict_t  v;
            bit [31:0] key;
            bit [31:0] bp[3];
            bit        keyed;
            bit        hit;
            v = '0;
            if (!(s.has_payload || s.syn_flag || s.fin_flag || s.rst_flag))
            begin
                verdict_q.push_back(v);
                return;
            end
            if (s.timestamp_ns > epoch_start &&
                s.timestamp_ns - epoch_start > 64'(epoch_len))
            begin
                epoch_start = s.timestamp_ns;
                generation  = generation + 64'd1;
            end
            keyed = 1'b1;
            key   = '0;
            if (s.has_payload)
                key = s.seq_num >> 4;
            else if (s.syn_flag && !s.ack_flag)
                key = s.seq_num;
            else
                keyed = 1'b0;
            if (keyed)
            begin
                hit = 1'b1;
                for (int k = 0; k < NUM_HASH; k++)
                begin
                    bp[k] = spread(HASH_SEEDS[k], s, key) % HALF_BITS;
                    hit = hit & (seen(bp[k], generation) ||
                                 seen(bp[k], generation - 64'd1));
                end
                for (int k = 0; k < NUM_HASH; k++)
                    set_bit(bp[k], generation);
                v.was_tested    = 1'b1;
                v.is_retransmit = hit;
            end
            verdict_q.push_back(v);
        endfunction

        function void check_verdict(bit tested, bit retx);
            verdict_t e;
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tested=%0b retransmit=%0b", tested, retx);
                return;
            end
            e = verdict_q.pop_front();
            if (e.was_tested != tested || e.is_retransmit != retx)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected tested=%0b retransmit=%0b, got tested=%0b retransmit=%0b",
                             e.was_tested, e.is_retransmit, tested, retx);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [EPOCH_W-1:0] cfg_wdata;

    abrd_seg_if seg_ch();
    abrd_res_if res_ch();

    aging_bloom_retransmit_detector_top #(
        .WORDS_PER_HALF (HALF_WORDS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bloom_shadow        shadow;
    int unsigned        tx_idle_pct = 29;
    int unsigned        rx_idle_pct = 65;
    int unsigned        stall_len   = 0;
    bit [63:0]          clock_ns;
    bit [EPOCH_W-1:0]   cur_len;
    flow_t              flows[8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_len != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
                stall_len = 0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            shadow.check_verdict(res_ch.was_tested, res_ch.is_retransmit);
    end

    function automatic tcp_seg_t mk(bit [31:0] sa, bit [31:0] da, bit [15:0] sp,
                                    bit [15:0] dp, bit [31:0] seq, bit [4:0] fl,
                                    bit [63:0] ts);
        tcp_seg_t s;
        s.src_addr     = sa;
        s.dst_addr     = da;
        s.src_port     = sp;
        s.dst_port     = dp;
        s.seq_num      = seq;
        s.has_payload  = fl[4];
        s.syn_flag     = fl[3];
        s.ack_flag     = fl[2];
        s.fin_flag     = fl[1];
        s.rst_flag     = fl[0];
        s.timestamp_ns = ts;
        return s;
    endfunction

    function automatic bit pure_ack(tcp_seg_t s);
        return !(s.has_payload || s.syn_flag || s.fin_flag || s.rst_flag);
    endfunction

    function automatic bit [63:0] next_stamp();
        case ($urandom_range(0, 19))
            0, 1: clock_ns = clock_ns + 64'(cur_len) + $urandom_range(1, 2000);
            2: ;
            3: return clock_ns - $urandom_range(1, 5000);
            default: clock_ns = clock_ns + $urandom_range(0, 3000) +
                                (64'(cur_len) >> $urandom_range(3, 8));
        endcase
        return clock_ns;
    endfunction

    function automatic void new_flow(int f);
        flows[f].sa       = $urandom;
        flows[f].da       = $urandom;
        flows[f].sp       = $urandom;
        flows[f].dp       = $urandom;
        flows[f].data_seq = $urandom;
        flows[f].syn_seq  = $urandom;
    endfunction

    function automatic tcp_seg_t random_segment();
        tcp_seg_t s;
        int       f;
        int       k;
        f = $urandom_range(0, 7);
        k = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3)
            new_flow(f);
        s = mk(flows[f].sa, flows[f].da, flows[f].sp, flows[f].dp, flows[f].data_seq,
               F_PAY, 64'd0);
        s.ack_flag = $urandom_range(0, 1);
        s.fin_flag = ($urandom_range(0, 15) == 0);
        s.rst_flag = ($urandom_range(0, 31) == 0);
        if (k < 40)
        begin
            s.seq_num = {flows[f].data_seq[31:4], 4'($urandom_range(0, 15))};
        end
        else if (k < 65)
        begin
            flows[f].data_seq = flows[f].data_seq + $urandom_range(1, 1500);
            s.seq_num = flows[f].data_seq;
            s.syn_flag = ($urandom_range(0, 7) == 0);
        end
        else if (k < 77)
        begin
            if ($urandom_range(0, 1) == 0)
                flows[f].syn_seq = $urandom;
            s.seq_num     = flows[f].syn_seq;
            s.has_payload = 1'b0;
            s.syn_flag    = 1'b1;
            s.ack_flag    = 1'b0;
        end
        else
        begin
            s = mk($urandom, $urandom, $urandom, $urandom, $urandom,
                   5'($urandom_range(0, 31)), 64'd0);
            if (pure_ack(s))
            begin
                s.timestamp_ns = {32'($urandom), 32'($urandom)};
                return s;
            end
        end
        s.timestamp_ns = next_stamp();
        return s;
    endfunction

    task automatic send_segment(input tcp_seg_t s);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.src_addr     <= s.src_addr;
        seg_ch.dst_addr     <= s.dst_addr;
        seg_ch.src_port     <= s.src_port;
        seg_ch.dst_port     <= s.dst_port;
        seg_ch.seq_num      <= s.seq_num;
        seg_ch.has_payload  <= s.has_payload;
        seg_ch.syn_flag     <= s.syn_flag;
        seg_ch.ack_flag     <= s.ack_flag;
        seg_ch.fin_flag     <= s.fin_flag;
        seg_ch.rst_flag     <= s.rst_flag;
        seg_ch.timestamp_ns <= s.timestamp_ns;
        seg_ch.valid        <= 1'b1;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
        shadow.note_segment(s);
    endtask

    // drop the request and hold until every result is back
    task automatic drain();
        seg_ch.valid <= 1'b0;
        while (shadow.verdict_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_epoch(input bit [EPOCH_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow.set_epoch(v);
        cur_len = v;
    endtask

    initial
    begin
        bit [63:0]        lp;
        bit [EPOCH_W-1:0] lens[6];
        tcp_seg_t         s;
        int unsigned      n;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        seg_ch.valid        = 1'b0;
        seg_ch.src_addr     = '0;
        seg_ch.dst_addr     = '0;
        seg_ch.src_port     = '0;
        seg_ch.dst_port     = '0;
        seg_ch.seq_num      = '0;
        seg_ch.has_payload  = 1'b0;
        seg_ch.syn_flag     = 1'b0;
        seg_ch.ack_flag     = 1'b0;
        seg_ch.fin_flag     = 1'b0;
        seg_ch.rst_flag     = 1'b0;
        seg_ch.timestamp_ns = '0;
        shadow  = new();
        cur_len = EPOCH_RESET;
        lp      = 64'(EPOCH_RESET);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_segment(mk(0, 0, 0, 0, 0, F_NONE, 64'd0));
        send_segment(mk('1, '1, '1, '1, '1, F_ACK, '1));
        send_segment(mk(32'h0a000001, 32'h0a000002, 16'd443, 16'd50000, 32'h10000040,
                        F_PAY | F_ACK, 64'd1000));
        send_segment(mk(32'h0a000001, 32'h0a000002, 16'd443, 16'd50000, 32'h1000004f,
                        F_PAY | F_ACK, 64'd1100));
        send_segment(mk(32'h0a000001, 32'h0a000002, 16'd443, 16'd50000, 32'h10000040,
                        F_PAY, 64'd1200));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'habcd0001,
                        F_SYN, 64'd2000));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'habcd0001,
                        F_SYN, 64'd2100));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'habcd0001,
                        F_SYN | F_ACK, 64'd3000));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'h5, F_FIN, 64'd3100));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'h6, F_RST, 64'd3200));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'h77,
                        F_SYN | F_FIN | F_RST, 64'd3300));
        send_segment(mk(32'h08080808, 32'h01010101, 16'd53, 16'd53, 32'h00002000,
                        F_PAY | F_SYN | F_ACK, 64'd3400));
        send_segment(mk('1, '1, '1, '1, '1, F_PAY | F_SYN | F_ACK | F_FIN | F_RST,
                        64'd4000));
        send_segment(mk('1, '1, '1, '1, '1, F_PAY, 64'd4100));
        send_segment(mk(0, 0, 0, 0, 0, F_PAY, 64'd0));
        send_segment(mk(32'h0a000001, 32'h0a000002, 16'd443, 16'd50000, 32'h10000041,
                        F_PAY, lp));
        send_segment(mk(32'h0a000001, 32'h0a000002, 16'd443, 16'd50000, 32'h10000042,
                        F_PAY, lp + 1));
        send_segment(mk(32'h0a000001, 32'h0a000002, 16'd443, 16'd50000, 32'h10000043,
                        F_PAY, 2 * lp + 2));
        send_segment(mk(32'h08080808, 32'h01010101, 16'd53, 16'd53, 32'h00002000,
                        F_PAY, 3 * lp + 3));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'habcd0001,
                        F_SYN, 4 * lp + 4));
        send_segment(mk(32'hc0a80101, 32'hc0a80102, 16'd1234, 16'd80, 32'habcd0001,
                        F_SYN, 4 * lp + 5));
        drain();

        clock_ns = 4 * lp + 10;
        for (int f = 0; f < 8; f++)
            new_flow(f);

        lens = '{EPOCH_RESET, '0, EPOCH_MAX, 40'd5000, 40'd200000, EPOCH_RESET};
        for (int p = 0; p < 6; p++)
        begin
            write_epoch(lens[p]);
            if (p < 2)
            begin
                tx_idle_pct = 29;
                rx_idle_pct = 65;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 65;
                rx_idle_pct = 29;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 3)
                stall_len = 400;
            n = 0;
            while (n < 280)
            begin
                s = random_segment();
                send_segment(s);
                if (!pure_ack(s))
                    n++;
            end
            drain();
        end

        if (shadow.mismatches == 0 && shadow.verdict_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/abrd_pkg.sv
hw/rtl/abrd_if.sv
hw/rtl/abrd_ram.sv
hw/rtl/aging_bloom_retransmit_detector_top.sv
tb/tb_top.sv
